[hw/rtl/linear_resampler_channel_mix_core_assert.svh]
// Assertion macros for the linear resampler core.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef LINEAR_RESAMPLER_CHANNEL_MIX_CORE_ASSERT_SVH
`define LINEAR_RESAMPLER_CHANNEL_MIX_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LRCM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LRCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lrcm_pkg.sv]
// Shared types and constants for the linear resampler with channel map.
// Depends on nothing; used by linear_resampler_channel_mix_core.
`default_nettype none

package lrcm_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int MAX_CHANNELS   = 8;
   localparam int MAX_OUTPUTS    = 16;
   localparam int CH_IDX_WIDTH   = $clog2(MAX_CHANNELS);
   localparam int MAC_CNT_WIDTH  = $clog2(MAX_CHANNELS + 1);
   localparam int CHAN_CNT_WIDTH = 4;
   localparam int POS_WIDTH      = 20;
   localparam int STEP_WIDTH     = 20;
   localparam int FRAC_WIDTH     = 16;
   localparam int PROD_WIDTH     = SAMPLE_WIDTH + 1 + FRAC_WIDTH + 1;

   localparam logic [POS_WIDTH-1:0] Q_ONE   = POS_WIDTH'(1) << FRAC_WIDTH;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] CSR_RESAMPLE_ENABLE = 2'd0;
   localparam logic [1:0] CSR_STEP            = 2'd1;
   localparam logic [1:0] CSR_IN_CHANNELS     = 2'd2;
   localparam logic [1:0] CSR_OUT_CHANNELS    = 2'd3;

   localparam logic [STEP_WIDTH-1:0]     STEP_RESET = STEP_WIDTH'(65536);
   localparam logic [CHAN_CNT_WIDTH-1:0] CHAN_RESET = CHAN_CNT_WIDTH'(2);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic       restart;
      sample_type s0;
      sample_type s1;
      sample_type s2;
      sample_type s3;
      sample_type s4;
      sample_type s5;
      sample_type s6;
      sample_type s7;
   } req_word_type;

   typedef struct packed {
      sample_type o0;
      sample_type o1;
      sample_type o2;
      sample_type o3;
      sample_type o4;
      sample_type o5;
      sample_type o6;
      sample_type o7;
      logic       last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_MAC,
      ST_EMIT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/linear_resampler_channel_mix_core.sv]
// Linear-interpolation sample-rate converter: the sequencer, the shared
// multiplier and the channel map, with its APB-style register port.
// Depends on lrcm_pkg and linear_resampler_channel_mix_core_assert.svh.
`default_nettype none

`include "linear_resampler_channel_mix_core_assert.svh"

// One source frame is taken per req word; the block then stays busy until all
// output words caused by that frame have been computed. A frame in pass-through
// mode passes through ST_EMIT and ST_FINISH; one that only primes the history
// (restart) goes straight to ST_FINISH. With resampling on, each output word
// takes one loop test, an ST_MAC pass in which a single 17x17 multiplier works
// through the eight channels one per cycle with the add in the next cycle, and
// an ST_EMIT step to load the output register; a frame gives at most 16 words,
// and a finished word may wait on rsp_stall. The output register parts the two
// sides: while a word waits on rsp_stall the block only pauses when the next
// word is ready, and goes through ST_FINISH back to idle for a new frame once
// its last word is loaded. Registers: 0x0 resample enable, 0x4 step (Q4.16),
// 0x8 source channel count, 0xC output channel count; write only while idle.
module linear_resampler_channel_mix_core #(
   parameter int MAX_OUTPUTS = lrcm_pkg::MAX_OUTPUTS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  lrcm_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output lrcm_pkg::rsp_word_type                rsp_word,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [lrcm_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire  [lrcm_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [lrcm_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
   localparam int SW    = lrcm_pkg::SAMPLE_WIDTH;
   localparam int NCH   = lrcm_pkg::MAX_CHANNELS;
   localparam int PW    = lrcm_pkg::POS_WIDTH;
   localparam int FW    = lrcm_pkg::FRAC_WIDTH;
   localparam int PRW   = lrcm_pkg::PROD_WIDTH;
   localparam int CCW   = lrcm_pkg::CHAN_CNT_WIDTH;
   localparam int MCW   = lrcm_pkg::MAC_CNT_WIDTH;
   localparam int CIW   = lrcm_pkg::CH_IDX_WIDTH;

   // Configuration registers
   logic                           enable_ff;
   logic [lrcm_pkg::STEP_WIDTH-1:0] step_ff;
   logic [CCW-1:0]                 in_ch_ff;
   logic [CCW-1:0]                 out_ch_ff;

   // Sequencer and datapath state
   lrcm_pkg::state_type   state_ff, state_in;
   logic                  primed_ff;
   logic [PW-1:0]         position_ff;
   logic [CNT_W-1:0]      out_cnt_ff;
   logic [MCW-1:0]        mac_cnt_ff;
   logic                  pass_ff;
   logic                  zero_pos_ff;
   lrcm_pkg::sample_type  cur_ff   [NCH];
   lrcm_pkg::sample_type  prev_ff  [NCH];
   lrcm_pkg::sample_type  mixed_ff [NCH];
   lrcm_pkg::sample_type  prev_pipe_ff;
   logic signed [PRW-1:0] prod_ff;
   logic                  rsp_valid_ff;
   lrcm_pkg::rsp_word_type rsp_word_ff;

   // Combinational signals
   logic                  req_accept;
   logic                  csr_write;
   logic                  rsp_free;
   logic                  load_rsp;
   logic                  emit_last;
   logic [PW:0]           pos_sum;
   logic [PW-1:0]         pos_next;
   logic [CNT_W-1:0]      cnt_plus;
   logic [CIW-1:0]        mul_idx;
   logic [MCW-1:0]        wr_cnt;
   logic [CIW-1:0]        wr_idx;
   logic signed [SW:0]    diff;
   logic signed [FW:0]    frac;
   logic signed [SW+1:0]  mix_sum;
   logic signed [SW:0]    avg_sum;
   logic                  map_ok;
   lrcm_pkg::sample_type  src_frame [NCH];
   lrcm_pkg::sample_type  mapped    [NCH];
   lrcm_pkg::rsp_word_type rsp_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      case (csr_paddr[3:2])
         lrcm_pkg::CSR_RESAMPLE_ENABLE: csr_prdata = 32'(enable_ff);
         lrcm_pkg::CSR_STEP:            csr_prdata = 32'(step_ff);
         lrcm_pkg::CSR_IN_CHANNELS:     csr_prdata = 32'(in_ch_ff);
         lrcm_pkg::CSR_OUT_CHANNELS:    csr_prdata = 32'(out_ch_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // Position advance with saturation at the top of the 20-bit range.
   assign pos_sum   = {1'b0, position_ff} + {1'b0, step_ff};
   assign pos_next  = pos_sum[PW] ? lrcm_pkg::POS_MAX : pos_sum[PW-1:0];
   assign cnt_plus  = out_cnt_ff + CNT_W'(1);
   assign emit_last = pass_ff ||
                      !((pos_next < lrcm_pkg::Q_ONE) && (cnt_plus < CNT_W'(MAX_OUTPUTS)));

   // Shared multiplier operands for channel mac_cnt; registered product added for mac_cnt - 1.
   assign mul_idx = mac_cnt_ff[CIW-1:0];
   assign wr_cnt  = mac_cnt_ff - MCW'(1);
   assign wr_idx  = wr_cnt[CIW-1:0];
   assign diff    = $signed({cur_ff[mul_idx][SW-1], cur_ff[mul_idx]}) -
                    $signed({prev_ff[mul_idx][SW-1], prev_ff[mul_idx]});
   assign frac    = $signed({1'b0, position_ff[FW-1:0]});
   // The arithmetic shift by the fraction width floors toward minus infinity.
   assign mix_sum = $signed({{2{prev_pipe_ff[SW-1]}}, prev_pipe_ff}) +
                    $signed(prod_ff[PRW-1:FW]);

   // Channel map
   always_comb begin
      map_ok  = (in_ch_ff inside {[1:NCH]}) && (out_ch_ff inside {[1:NCH]});
      for (int c = 0; c < NCH; c++) begin
         src_frame[c] = pass_ff ? cur_ff[c] : mixed_ff[c];
         mapped[c]    = '0;
      end
      avg_sum = $signed({src_frame[0][SW-1], src_frame[0]}) +
                $signed({src_frame[1][SW-1], src_frame[1]});
      if (map_ok) begin
         if (in_ch_ff == out_ch_ff) begin
            for (int c = 0; c < NCH; c++) begin
               if (CCW'(c) < out_ch_ff) begin
                  mapped[c] = src_frame[c];
               end
            end
         end else if (in_ch_ff == CCW'(1) && out_ch_ff == CCW'(2)) begin
            mapped[0] = src_frame[0];
            mapped[1] = src_frame[0];
         end else if (in_ch_ff == CCW'(2) && out_ch_ff == CCW'(1)) begin
            mapped[0] = avg_sum[SW:1];
         end
      end
      rsp_next.o0   = mapped[0];
      rsp_next.o1   = mapped[1];
      rsp_next.o2   = mapped[2];
      rsp_next.o3   = mapped[3];
      rsp_next.o4   = mapped[4];
      rsp_next.o5   = mapped[5];
      rsp_next.o6   = mapped[6];
      rsp_next.o7   = mapped[7];
      rsp_next.last = emit_last;
   end

   // Sequencer: next state and handshake outputs
   always_comb begin
      state_in   = state_ff;
      req_stall  = (state_ff != lrcm_pkg::ST_IDLE);
      req_accept = req_valid & ~req_stall;
      load_rsp   = 1'b0;
      case (state_ff)
         lrcm_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (!enable_ff) begin
                  state_in = lrcm_pkg::ST_EMIT;
               end else if (req_word.restart || !primed_ff) begin
                  state_in = lrcm_pkg::ST_FINISH;
               end else begin
                  state_in = lrcm_pkg::ST_TEST;
               end
            end
         end
         lrcm_pkg::ST_TEST: begin
            if (position_ff < lrcm_pkg::Q_ONE && out_cnt_ff < CNT_W'(MAX_OUTPUTS)) begin
               state_in = lrcm_pkg::ST_MAC;
            end else begin
               state_in = lrcm_pkg::ST_FINISH;
            end
         end
         lrcm_pkg::ST_MAC: begin
            if (mac_cnt_ff == MCW'(NCH)) begin
               state_in = lrcm_pkg::ST_EMIT;
            end
         end
         lrcm_pkg::ST_EMIT: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = emit_last ? lrcm_pkg::ST_FINISH : lrcm_pkg::ST_TEST;
            end
         end
         lrcm_pkg::ST_FINISH: begin
            state_in = lrcm_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrcm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         step_ff      <= lrcm_pkg::STEP_RESET;
         in_ch_ff     <= lrcm_pkg::CHAN_RESET;
         out_ch_ff    <= lrcm_pkg::CHAN_RESET;
         primed_ff    <= 1'b0;
         position_ff  <= '0;
         out_cnt_ff   <= '0;
         mac_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_paddr[3:2])
               lrcm_pkg::CSR_RESAMPLE_ENABLE: enable_ff <= csr_pwdata[0];
               lrcm_pkg::CSR_STEP:            step_ff   <= csr_pwdata[PW-1:0];
               lrcm_pkg::CSR_IN_CHANNELS:     in_ch_ff  <= csr_pwdata[CCW-1:0];
               lrcm_pkg::CSR_OUT_CHANNELS:    out_ch_ff <= csr_pwdata[CCW-1:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            out_cnt_ff <= '0;
         end
         if (state_ff == lrcm_pkg::ST_TEST) begin
            mac_cnt_ff <= '0;
         end else if (state_ff == lrcm_pkg::ST_MAC) begin
            mac_cnt_ff <= mac_cnt_ff + MCW'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            if (!pass_ff) begin
               position_ff <= pos_next;
               out_cnt_ff  <= cnt_plus;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == lrcm_pkg::ST_FINISH) begin
            primed_ff <= 1'b1;
            if (zero_pos_ff || position_ff < lrcm_pkg::Q_ONE) begin
               position_ff <= '0;
            end else begin
               position_ff <= position_ff - lrcm_pkg::Q_ONE;
            end
         end
      end
   end

   // Sample and result registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_ff[0]   <= req_word.s0;
         cur_ff[1]   <= req_word.s1;
         cur_ff[2]   <= req_word.s2;
         cur_ff[3]   <= req_word.s3;
         cur_ff[4]   <= req_word.s4;
         cur_ff[5]   <= req_word.s5;
         cur_ff[6]   <= req_word.s6;
         cur_ff[7]   <= req_word.s7;
         pass_ff     <= ~enable_ff;
         zero_pos_ff <= ~enable_ff | req_word.restart | ~primed_ff;
      end
      if (state_ff == lrcm_pkg::ST_MAC) begin
         if (mac_cnt_ff < MCW'(NCH)) begin
            prod_ff      <= PRW'(diff * frac);
            prev_pipe_ff <= prev_ff[mul_idx];
         end
         if (mac_cnt_ff != '0) begin
            mixed_ff[wr_idx] <= mix_sum[SW-1:0];
         end
      end
      if (load_rsp) begin
         rsp_word_ff <= rsp_next;
      end
      if (state_ff == lrcm_pkg::ST_FINISH) begin
         for (int c = 0; c < NCH; c++) begin
            prev_ff[c] <= cur_ff[c];
         end
      end
   end

   `LRCM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      out_cnt_ff <= CNT_W'(MAX_OUTPUTS), "output count ran past the limit")
   `LRCM_ASSERT_SAME(a_frac_in_range, clock, reset, state_ff == lrcm_pkg::ST_MAC,
      position_ff < lrcm_pkg::Q_ONE, "interpolation started with position at or above one")
   `LRCM_ASSERT_NEXT(a_emit_waits, clock, reset,
      state_ff == lrcm_pkg::ST_EMIT && rsp_valid_ff && rsp_stall,
      state_ff == lrcm_pkg::ST_EMIT && $stable(rsp_word_ff), "pending word was overwritten")
   `LRCM_ASSERT_NEXT(a_pass_single, clock, reset,
      load_rsp && pass_ff, rsp_word_ff.last && state_ff == lrcm_pkg::ST_FINISH,
      "pass-through frame did not end with one last word")

endmodule

`default_nettype wire

[sim/linear_resampler_channel_mix_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for linear_resampler_channel_mix_core: directed and random
// source frames, a frame predictor with a scoreboard on the output words.
// Depends on lrcm_pkg and the core RTL.

module linear_resampler_channel_mix_core_tb;

   localparam int SAMPLE_WIDTH   = lrcm_pkg::SAMPLE_WIDTH;
   localparam int MAX_CHANNELS   = lrcm_pkg::MAX_CHANNELS;
   localparam int MAX_OUTPUTS    = lrcm_pkg::MAX_OUTPUTS;
   localparam int FRAC_WIDTH     = lrcm_pkg::FRAC_WIDTH;
   localparam int CSR_ADDR_WIDTH = lrcm_pkg::CSR_ADDR_WIDTH;
   localparam int CSR_DATA_WIDTH = lrcm_pkg::CSR_DATA_WIDTH;

   typedef longint frame_type [MAX_CHANNELS];

   class resample_scoreboard;
      lrcm_pkg::rsp_word_type expected_q[$];
      int           errors;
      bit           resample_on;
      int unsigned  step_q16;
      int unsigned  in_count;
      int unsigned  out_count;
      frame_type    history;
      int unsigned  read_pos;
      bit           have_history;

      function new();
         errors       = 0;
         resample_on  = 1'b0;
         step_q16     = 65536;
         in_count     = 2;
         out_count    = 2;
         read_pos     = 0;
         have_history = 1'b0;
         foreach (history[c]) history[c] = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [1:0] idx, int unsigned value);
         case (idx)
            lrcm_pkg::CSR_RESAMPLE_ENABLE: resample_on = value[0];
            lrcm_pkg::CSR_STEP:            step_q16 = value & 32'hF_FFFF;
            lrcm_pkg::CSR_IN_CHANNELS:     in_count = value & 32'hF;
            lrcm_pkg::CSR_OUT_CHANNELS:    out_count = value & 32'hF;
            default: ;
         endcase
      endfunction

      function int unsigned reg_value(logic [1:0] idx);
         case (idx)
            lrcm_pkg::CSR_RESAMPLE_ENABLE: return resample_on;
            lrcm_pkg::CSR_STEP:            return step_q16;
            lrcm_pkg::CSR_IN_CHANNELS:     return in_count;
            default:                       return out_count;
         endcase
      endfunction

      // Channel map; unsupported count pairs give silence.
      function lrcm_pkg::rsp_word_type map_channels(frame_type f);
         lrcm_pkg::rsp_word_type w;
         longint       avg;
         w = '0;
         if (in_count >= 1 && in_count <= MAX_CHANNELS &&
             out_count >= 1 && out_count <= MAX_CHANNELS) begin
            if (in_count == out_count) begin
               for (int c = 0; c < out_count; c++)
                  w[SAMPLE_WIDTH*(MAX_CHANNELS-c) -: SAMPLE_WIDTH] = SAMPLE_WIDTH'(f[c]);
            end else if (in_count == 1 && out_count == 2) begin
               w.o0 = SAMPLE_WIDTH'(f[0]);
               w.o1 = SAMPLE_WIDTH'(f[0]);
            end else if (in_count == 2 && out_count == 1) begin
               avg  = (f[0] + f[1]) >>> 1;
               w.o0 = SAMPLE_WIDTH'(avg);
            end
         end
         return w;
      endfunction

      function void take_source_frame(lrcm_pkg::req_word_type w);
         frame_type    cur;
         frame_type    mixed;
         lrcm_pkg::rsp_word_type r;
         int unsigned  next_pos;
         int           n;
         for (int c = 0; c < MAX_CHANNELS; c++)
            cur[c] = longint'(lrcm_pkg::sample_type'(
                        w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH]));
         if (!resample_on) begin
            r = map_channels(cur);
            r.last = 1'b1;
            expected_q.push_back(r);
            history      = cur;
            read_pos     = 0;
            have_history = 1'b1;
            return;
         end
         if (w.restart || !have_history) begin
            history      = cur;
            read_pos     = 0;
            have_history = 1'b1;
            return;
         end
         n = 0;
         while (read_pos < lrcm_pkg::Q_ONE && n < MAX_OUTPUTS) begin
            for (int c = 0; c < MAX_CHANNELS; c++)
               mixed[c] = history[c] +
                          (((cur[c] - history[c]) * longint'(read_pos)) >>> FRAC_WIDTH);
            expected_q.push_back(map_channels(mixed));
            next_pos = read_pos + step_q16;
            read_pos = (next_pos > lrcm_pkg::POS_MAX) ? lrcm_pkg::POS_MAX : next_pos;
            n++;
         end
         // A step too small to reach 1.0 within the output cap clears the position.
         read_pos = (read_pos >= lrcm_pkg::Q_ONE) ? read_pos - lrcm_pkg::Q_ONE : 0;
         history  = cur;
         if (n > 0) begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
         end
      endfunction

      function void check_output_frame(lrcm_pkg::rsp_word_type got);
         lrcm_pkg::rsp_word_type want;
         if (expected_q.size() == 0) begin
            $display("%0t ns: output word %h arrived with none expected", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (got[SAMPLE_WIDTH*(MAX_CHANNELS-c) -: SAMPLE_WIDTH] !==
                want[SAMPLE_WIDTH*(MAX_CHANNELS-c) -: SAMPLE_WIDTH]) begin
               $display("%0t ns: o%0d expected %0d, got %0d", $time, c,
                  lrcm_pkg::sample_type'(want[SAMPLE_WIDTH*(MAX_CHANNELS-c) -: SAMPLE_WIDTH]),
                  lrcm_pkg::sample_type'(got[SAMPLE_WIDTH*(MAX_CHANNELS-c) -: SAMPLE_WIDTH]));
               errors++;
            end
         end
         if (got.last !== want.last) begin
            $display("%0t ns: last expected %b, got %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   lrcm_pkg::req_word_type    req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lrcm_pkg::rsp_word_type    rsp_word;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   resample_scoreboard sb;
   bit                 hold_off_pending = 1'b0;
   bit                 sender_no_gaps = 1'b0;

   linear_resampler_channel_mix_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_output_frame(rsp_word);
   end

   // Receiver back-pressure: runs of stall and of no stall, plus one long hold-off.
   initial begin : rsp_stall_driver
      int pick;
      int run;
      wait (!reset);
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            run = 600;
         end else if (pick < 45) begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 12);
         end else if (pick < 55) begin
            rsp_stall <= 1'b0;
            run = $urandom_range(50, 200);
         end else if (pick < 92) begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            run = $urandom_range(10, 40);
         end
         repeat (run) @(posedge clock);
      end
   end

   task automatic send_frame(lrcm_pkg::req_word_type w);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (sender_no_gaps || pick < 50)
         gap = 0;
      else if (pick < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_source_frame(w);
   endtask

   // Frames that prime the history give no word, so allow a full frame time after
   // the last expected word before touching the registers.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_access(logic [1:0] idx, bit is_write, int unsigned wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_and_verify(logic [1:0] idx, int unsigned value);
      logic [CSR_DATA_WIDTH-1:0] rdata;
      csr_access(idx, 1'b1, value, rdata);
      sb.write_reg(idx, value);
      csr_access(idx, 1'b0, 0, rdata);
      if (rdata !== CSR_DATA_WIDTH'(sb.reg_value(idx))) begin
         $display("%0t ns: register %0d expected %h, read %h", $time, idx,
                  sb.reg_value(idx), rdata);
         sb.errors++;
      end
   endtask

   task automatic configure(bit en, int unsigned step_val, int unsigned in_ch,
                            int unsigned out_ch);
      write_and_verify(lrcm_pkg::CSR_RESAMPLE_ENABLE, en);
      write_and_verify(lrcm_pkg::CSR_STEP, step_val);
      write_and_verify(lrcm_pkg::CSR_IN_CHANNELS, in_ch);
      write_and_verify(lrcm_pkg::CSR_OUT_CHANNELS, out_ch);
   endtask

   function automatic lrcm_pkg::req_word_type flat_frame(bit restart, int v);
      lrcm_pkg::req_word_type w;
      w = '0;
      w.restart = restart;
      for (int c = 0; c < MAX_CHANNELS; c++)
         w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH] = SAMPLE_WIDTH'(v);
      return w;
   endfunction

   function automatic lrcm_pkg::req_word_type random_frame(bit restart);
      lrcm_pkg::req_word_type w;
      int           pick;
      w = '0;
      w.restart = restart;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH] =
               {1'b1, {SAMPLE_WIDTH-1{1'b0}}};
         else if (pick == 1)
            w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH] =
               {1'b0, {SAMPLE_WIDTH-1{1'b1}}};
         else if (pick < 4)
            w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH] =
               SAMPLE_WIDTH'($urandom_range(0, 63) - 32);
         else
            w[SAMPLE_WIDTH*(MAX_CHANNELS-c)-1 -: SAMPLE_WIDTH] = SAMPLE_WIDTH'($urandom());
      end
      return w;
   endfunction

   initial begin : stimulus
      lrcm_pkg::req_word_type w;
      int           pick;
      int unsigned  step_val;
      int unsigned  in_ch;
      int unsigned  out_ch;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first frame after reset only primes the history, even without restart.
      configure(1'b1, 32768, 8, 8);
      send_frame(flat_frame(1'b0, -32768));
      send_frame(flat_frame(1'b0, 32767));
      send_frame(flat_frame(1'b0, -32768));
      send_frame(flat_frame(1'b1, 0));
      send_frame(flat_frame(1'b0, 100));

      // Pass-through, where restart has no effect.
      drain_and_settle();
      configure(1'b0, 32768, 2, 2);
      send_frame(flat_frame(1'b0, -32768));
      send_frame(flat_frame(1'b0, 32767));
      send_frame(flat_frame(1'b1, 5));

      // Smallest step that reaches 1.0 within the cap: sixteen words, mono duplicated to stereo.
      drain_and_settle();
      configure(1'b1, 4096, 1, 2);
      send_frame(flat_frame(1'b0, 1234));
      send_frame(flat_frame(1'b0, -7));

      // Step too small to reach 1.0 within the cap; stereo averaged to mono.
      drain_and_settle();
      configure(1'b1, 1000, 2, 1);
      w = flat_frame(1'b0, -32768);
      send_frame(w);
      w.s0 = 16'sh7FFF;
      send_frame(w);

      // Leave the position at one half, then overflow it with the largest step.
      drain_and_settle();
      configure(1'b1, 32'h18000, 3, 5);
      send_frame(flat_frame(1'b0, 300));
      drain_and_settle();
      configure(1'b1, 32'hF_FFFF, 3, 5);
      send_frame(flat_frame(1'b0, -300));
      send_frame(flat_frame(1'b0, 77));

      // Channel counts of zero and above the maximum.
      drain_and_settle();
      configure(1'b0, 65536, 0, 9);
      send_frame(flat_frame(1'b0, 12345));
      drain_and_settle();
      configure(1'b0, 65536, 15, 15);
      send_frame(flat_frame(1'b0, -12345));

      // Step of 8.0: some frames give no word at all.
      drain_and_settle();
      configure(1'b1, 524288, 8, 8);
      send_frame(flat_frame(1'b0, 4000));
      send_frame(flat_frame(1'b0, -4000));

      for (int phase = 0; phase < 12; phase++) begin
         drain_and_settle();
         pick = $urandom_range(0, 9);
         if (pick < 2)
            step_val = $urandom_range(4096, 16384);
         else if (pick < 8)
            step_val = $urandom_range(32768, 131072);
         else
            step_val = $urandom_range(131072, 524288);
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            in_ch  = $urandom_range(1, 8);
            out_ch = in_ch;
         end else if (pick < 7) begin
            in_ch  = 1;
            out_ch = 2;
         end else if (pick < 9) begin
            in_ch  = 2;
            out_ch = 1;
         end else begin
            in_ch  = $urandom_range(0, 15);
            out_ch = $urandom_range(0, 15);
         end
         configure($urandom_range(0, 4) != 0, step_val, in_ch, out_ch);
         sender_no_gaps = ($urandom_range(0, 3) == 0);
         if (phase == 4) begin
            // Long receiver hold-off while frames keep coming, to fill the block.
            sender_no_gaps   = 1'b1;
            hold_off_pending = 1'b1;
         end
         send_frame(random_frame(1'b1));
         for (int i = 0; i < 32; i++)
            send_frame(random_frame($urandom_range(0, 19) == 0));
      end

      drain_and_settle();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : run_limit
      #32000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
